[rtl/af_queue_random_drop_credit_dequeue_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the assured-forwarding descriptor queue
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef AF_QUEUE_RANDOM_DROP_CREDIT_DEQUEUE_UNIT_DEFINES_SVH
`define AF_QUEUE_RANDOM_DROP_CREDIT_DEQUEUE_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define AFQ_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define AFQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/afq_pkg.sv]
// ----------------------------------------------------------------------------
// afq_pkg
// Types, widths and constants shared by the descriptor queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package afq_pkg;

    // Field widths.
    localparam int LEN_W      = 9;
    localparam int TAG_W      = 16;
    localparam int IPLEN_W    = 16;
    localparam int RAND_W     = 14;
    localparam int CREDIT_W   = 20;
    localparam int UNIT_W     = 16;
    localparam int PCT_W      = 7;
    localparam int SCALE_W    = 14;
    localparam int PROD_W     = RAND_W + LEN_W;
    localparam int DESC_W     = TAG_W + 1 + IPLEN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic constants.
    localparam logic [SCALE_W-1:0]  PROB_SCALE       = 14'd10000;
    localparam logic [PCT_W-1:0]    PERCENT_SCALE    = 7'd100;
    localparam logic [CREDIT_W-1:0] CREDIT_UNITS_MAX = 20'd10;

    // Register reset values.
    localparam logic [LEN_W-1:0]   MAX_LENGTH_RST     = 9'd256;
    localparam logic [LEN_W-1:0]   THRESHOLD_LOW_RST  = 9'd64;
    localparam logic [LEN_W-1:0]   THRESHOLD_HIGH_RST = 9'd128;
    localparam logic [SCALE_W-1:0] DROP_SCALE_RST     = 14'd1000;
    localparam logic [UNIT_W-1:0]  CREDIT_UNIT_RST    = 16'd1500;

    // Operation codes.
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROP_PERCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_UNIT      = 3'd4;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } afq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } afq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } afq_status_t;

endpackage

`default_nettype wire

[rtl/af_queue_random_drop_credit_dequeue_unit.sv]
// The item is captured when it is accepted, and its result is registered at commit,
// which waits while the result register is still held. A new item is taken only after
// the last one is committed, as the descriptor store read and drop products are registered.
// Reset clears pointers, fill count, credit and the result flag and loads the
// register defaults; the descriptor store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// af_queue_random_drop_credit_dequeue_unit
// Descriptor queue with two-precedence random early drop on enqueue and
// credit-gated dequeue; controller and datapath joined by command and status.
// ----------------------------------------------------------------------------
`default_nettype none

module af_queue_random_drop_credit_dequeue_unit
    import afq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            op,
    input  wire logic                  drop_class,
    input  wire logic                  is_ip,
    input  wire logic [IPLEN_W-1:0]    ip_length,
    input  wire logic [TAG_W-1:0]      pkt_tag,
    input  wire logic [RAND_W-1:0]     rand_value,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       accepted,
    output logic                       out_valid,
    output logic [TAG_W-1:0]           out_tag,
    output logic                       out_is_ip,
    output logic [IPLEN_W-1:0]         out_ip_length,
    output logic [LEN_W-1:0]           queue_length,
    output logic [CREDIT_W-1:0]        credit
);

    afq_cmd_t    cmd;
    afq_status_t status;

    // Sequencer.
    afq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    afq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .drop_class    (drop_class),
        .is_ip         (is_ip),
        .ip_length     (ip_length),
        .pkt_tag       (pkt_tag),
        .rand_value    (rand_value),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .accepted      (accepted),
        .out_valid     (out_valid),
        .out_tag       (out_tag),
        .out_is_ip     (out_is_ip),
        .out_ip_length (out_ip_length),
        .queue_length  (queue_length),
        .credit        (credit)
    );

endmodule

`default_nettype wire

[rtl/afq_ram.sv]
// ----------------------------------------------------------------------------
// afq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module afq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/afq_ctrl.sv]
// ----------------------------------------------------------------------------
// afq_ctrl
// Two-state sequencer: take one item, then commit it once the result
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module afq_ctrl
    import afq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire afq_status_t status,
    output afq_cmd_t         cmd
);

    afq_state_t state_reg;
    afq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/afq_datapath.sv]
// ----------------------------------------------------------------------------
// afq_datapath
// Configuration registers, queue pointers, credit, drop arithmetic,
// descriptor store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "af_queue_random_drop_credit_dequeue_unit_defines.svh"

module afq_datapath
    import afq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire afq_cmd_t              cmd,
    output afq_status_t                status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            op,
    input  wire logic                  drop_class,
    input  wire logic                  is_ip,
    input  wire logic [IPLEN_W-1:0]    ip_length,
    input  wire logic [TAG_W-1:0]      pkt_tag,
    input  wire logic [RAND_W-1:0]     rand_value,
    input  wire logic                  res_ready,
    output logic                       res_valid,
    output logic                       accepted,
    output logic                       out_valid,
    output logic [TAG_W-1:0]           out_tag,
    output logic                       out_is_ip,
    output logic [IPLEN_W-1:0]         out_ip_length,
    output logic [LEN_W-1:0]           queue_length,
    output logic [CREDIT_W-1:0]        credit
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;

    // Configuration registers (percent is kept pre-scaled by 100).
    logic [LEN_W-1:0]   max_length_reg;
    logic [LEN_W-1:0]   threshold_low_reg;
    logic [LEN_W-1:0]   threshold_high_reg;
    logic [SCALE_W-1:0] drop_scale_reg;
    logic [UNIT_W-1:0]  credit_unit_reg;

    // Queue state.
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       tail_reg;
    logic [FW-1:0]       fill_reg;
    logic [CREDIT_W-1:0] credit_reg;
    logic [AW-1:0]       head_next;
    logic [AW-1:0]       tail_next;
    logic [FW-1:0]       fill_next;
    logic [CREDIT_W-1:0] credit_next;

    // Captured item and precomputed drop terms.
    logic [1:0]         op_reg;
    logic               ip_reg;
    logic [IPLEN_W-1:0] iplen_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               full_reg;
    logic               pass_reg;
    logic [PROD_W-1:0]  lhs_reg;
    logic [PROD_W-1:0]  rhs_reg;

    // Result register.
    logic                res_valid_reg;
    logic                res_accepted_reg;
    logic                res_out_valid_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic                res_is_ip_reg;
    logic [IPLEN_W-1:0]  res_len_reg;
    logic [LEN_W-1:0]    res_qlen_reg;
    logic [CREDIT_W-1:0] res_credit_reg;

    // Combinational terms.
    logic [CW-1:0]       fill_cw;
    logic [LEN_W-1:0]    len9;
    logic                full_c;
    logic                below_low;
    logic                below_high;
    logic [LEN_W-1:0]    span_c;
    logic [LEN_W-1:0]    diff_c;
    logic [SCALE_W-1:0]  scale_c;
    logic [DESC_W-1:0]   rd_data;
    logic [DESC_W-1:0]   wr_data;
    logic                enq_ok;
    logic                deq_go;
    logic                mem_we;
    logic [TAG_W-1:0]    head_tag;
    logic                head_ip;
    logic [IPLEN_W-1:0]  head_len;
    logic [CREDIT_W-1:0] credit_limit;
    logic [CW-1:0]       fill_next_cw;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg     <= MAX_LENGTH_RST;
            threshold_low_reg  <= THRESHOLD_LOW_RST;
            threshold_high_reg <= THRESHOLD_HIGH_RST;
            drop_scale_reg     <= DROP_SCALE_RST;
            credit_unit_reg    <= CREDIT_UNIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LENGTH:       max_length_reg     <= cfg_data[LEN_W-1:0];
                CFG_THRESHOLD_LOW:    threshold_low_reg  <= cfg_data[LEN_W-1:0];
                CFG_THRESHOLD_HIGH:   threshold_high_reg <= cfg_data[LEN_W-1:0];
                CFG_MAX_DROP_PERCENT: drop_scale_reg     <=
                    SCALE_W'(cfg_data[PCT_W-1:0]) * SCALE_W'(PERCENT_SCALE);
                CFG_CREDIT_UNIT:      credit_unit_reg    <= cfg_data[UNIT_W-1:0];
                default:              max_length_reg     <= max_length_reg;
            endcase
        end
    end

    // Drop terms from the current fill level and the incoming item.
    // When the queue is not full the fill level is below max_length,
    // so its low nine bits carry it exactly.
    always_comb
    begin
        fill_cw    = CW'(fill_reg);
        len9       = fill_cw[LEN_W-1:0];
        full_c     = (fill_cw >= CW'(max_length_reg)) || (fill_reg >= FW'(QUEUE_DEPTH));
        below_low  = fill_cw < CW'(threshold_low_reg);
        below_high = fill_cw < CW'(threshold_high_reg);
        if (drop_class)
        begin
            span_c  = max_length_reg - threshold_low_reg;
            diff_c  = len9 - threshold_low_reg;
            scale_c = PROB_SCALE;
        end
        else
        begin
            span_c  = max_length_reg - threshold_high_reg;
            diff_c  = len9 - threshold_high_reg;
            scale_c = drop_scale_reg;
        end
    end

    // Item capture: payload and cross-multiplied drop terms.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            ip_reg    <= is_ip;
            iplen_reg <= ip_length;
            tag_reg   <= pkt_tag;
            full_reg  <= full_c;
            pass_reg  <= below_low || (!drop_class && below_high);
            lhs_reg   <= PROD_W'(rand_value) * PROD_W'(span_c);
            rhs_reg   <= PROD_W'(diff_c) * PROD_W'(scale_c);
        end
    end

    // Descriptor store; the head entry is read when the item is taken.
    assign wr_data = {tag_reg, ip_reg, iplen_reg};

    afq_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tail_reg),
        .wdata (wr_data),
        .re    (cmd.capture),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    assign head_tag = rd_data[DESC_W-1:IPLEN_W+1];
    assign head_ip  = rd_data[IPLEN_W];
    assign head_len = rd_data[IPLEN_W-1:0];

    // Operation decisions and next queue state.
    always_comb
    begin
        enq_ok       = !full_reg && !(!pass_reg && (lhs_reg < rhs_reg));
        deq_go       = (fill_reg != '0) &&
                       (!head_ip || (CREDIT_W'(head_len) <= credit_reg));
        credit_limit = CREDIT_W'(credit_unit_reg) * CREDIT_UNITS_MAX;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        credit_next  = credit_reg;
        mem_we       = 1'b0;
        if (cmd.commit)
        begin
            case (op_reg)
                OP_ENQUEUE:
                begin
                    if (enq_ok)
                    begin
                        mem_we    = 1'b1;
                        tail_next = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (fill_reg == '0)
                    begin
                        credit_next = '0;
                    end
                    else if (deq_go)
                    begin
                        if (head_ip)
                        begin
                            credit_next = credit_reg - CREDIT_W'(head_len);
                        end
                        head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (credit_reg < credit_limit)
                    begin
                        credit_next = credit_reg + CREDIT_W'(credit_unit_reg);
                    end
                end
                default:
                begin
                    credit_next = credit_reg;
                end
            endcase
        end
        fill_next_cw = CW'(fill_next);
    end

    // Queue state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_accepted_reg  <= (op_reg == OP_ENQUEUE) && enq_ok;
            res_out_valid_reg <= (op_reg == OP_DEQUEUE) && deq_go;
            res_tag_reg       <= ((op_reg == OP_DEQUEUE) && deq_go) ? head_tag : '0;
            res_is_ip_reg     <= (op_reg == OP_DEQUEUE) && deq_go && head_ip;
            res_len_reg       <= ((op_reg == OP_DEQUEUE) && deq_go) ? head_len : '0;
            res_qlen_reg      <= fill_next_cw[LEN_W-1:0];
            res_credit_reg    <= credit_next;
        end
    end

    assign status.out_free = !res_valid_reg || res_ready;
    assign res_valid       = res_valid_reg;
    assign accepted        = res_accepted_reg;
    assign out_valid       = res_out_valid_reg;
    assign out_tag         = res_tag_reg;
    assign out_is_ip       = res_is_ip_reg;
    assign out_ip_length   = res_len_reg;
    assign queue_length    = res_qlen_reg;
    assign credit          = res_credit_reg;

    // Checks on queue bookkeeping and the result register.
    `AFQ_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FW'(QUEUE_DEPTH), "fill count above depth")
    `AFQ_ASSERT(a_no_overwrite, clk, rst_n, !cmd.commit || !res_valid_reg || res_ready, "result overwritten")
    `AFQ_ASSERT_NEXT(a_enq_count, clk, rst_n, cmd.commit && mem_we, fill_reg == $past(fill_reg) + 1'b1, "enqueue count slip")
    `AFQ_ASSERT_NEXT(a_deq_count, clk, rst_n, cmd.commit && (op_reg == OP_DEQUEUE) && deq_go, fill_reg == $past(fill_reg) - 1'b1, "dequeue count slip")

endmodule

`default_nettype wire

[test/af_queue_random_drop_credit_dequeue_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// af_queue_random_drop_credit_dequeue_unit_tb
// Self-checking bench for the descriptor queue. A directed table walks the
// special cases of enqueue, dequeue and credit tick, then several register
// settings each run random traffic. A shadow queue predicts every result.
// ----------------------------------------------------------------------------

module af_queue_random_drop_credit_dequeue_unit_tb;

    import afq_pkg::*;

    localparam int                  SHADOW_DEPTH    = 256;
    localparam logic [1:0]          OP_RESERVED     = 2'd3;
    localparam logic [CREDIT_W-1:0] CREDIT_MASK     = '1;
    localparam int unsigned         CYCLE_LIMIT     = 300000;
    localparam int                  DRAIN_CYCLES    = 4;
    localparam int                  HOLD_OFF_CYCLES = 300;
    localparam int                  PHASE_COUNT     = 6;

    // One input item, one result, and one stored descriptor.
    typedef struct packed {
        logic [1:0]         op;
        logic               drop_class;
        logic               is_ip;
        logic [IPLEN_W-1:0] ip_length;
        logic [TAG_W-1:0]   pkt_tag;
        logic [RAND_W-1:0]  rand_value;
    } pkt_item_t;

    typedef struct packed {
        logic               accepted;
        logic               out_valid;
        logic [TAG_W-1:0]   out_tag;
        logic               out_is_ip;
        logic [IPLEN_W-1:0] out_ip_length;
        logic [LEN_W-1:0]   queue_length;
        logic [CREDIT_W-1:0] credit;
    } queue_result_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               is_ip;
        logic [IPLEN_W-1:0] ip_length;
    } desc_t;

    // A row of the directed table is either an item or a register write.
    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        pkt_item_t             item;
        logic                  typed;
        queue_result_t         typed_res;
    } stim_row_t;

    // Register setting and operation mix of one random phase.
    typedef struct {
        int unsigned max_len;
        int unsigned thr_low;
        int unsigned thr_high;
        int unsigned drop_pct;
        int unsigned unit;
        int unsigned items;
        int unsigned enq_pct;
        int unsigned deq_pct;
        int unsigned tick_pct;
    } traffic_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            op;
    logic                  drop_class;
    logic                  is_ip;
    logic [IPLEN_W-1:0]    ip_length;
    logic [TAG_W-1:0]      pkt_tag;
    logic [RAND_W-1:0]     rand_value;
    logic                  res_valid;
    logic                  res_ready;
    logic                  accepted;
    logic                  out_valid;
    logic [TAG_W-1:0]      out_tag;
    logic                  out_is_ip;
    logic [IPLEN_W-1:0]    out_ip_length;
    logic [LEN_W-1:0]      queue_length;
    logic [CREDIT_W-1:0]   credit;

    // Shadow copy of the queue, the credit and the registers.
    desc_t           shadow_fifo[$];
    longint unsigned shadow_credit;
    longint unsigned cfg_max_len;
    longint unsigned cfg_thr_low;
    longint unsigned cfg_thr_high;
    longint unsigned cfg_drop_pct;
    longint unsigned cfg_unit;

    queue_result_t owed_results[$];
    int            error_count;
    int            burst_left;
    bit            hold_off_req;
    int unsigned   cycle_count = 0;

    af_queue_random_drop_credit_dequeue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .drop_class    (drop_class),
        .is_ip         (is_ip),
        .ip_length     (ip_length),
        .pkt_tag       (pkt_tag),
        .rand_value    (rand_value),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .accepted      (accepted),
        .out_valid     (out_valid),
        .out_tag       (out_tag),
        .out_is_ip     (out_is_ip),
        .out_ip_length (out_ip_length),
        .queue_length  (queue_length),
        .credit        (credit)
    );

    // Random early drop decision against the current shadow fill level.
    function automatic bit early_drop(logic cls, logic [RAND_W-1:0] rnd);
        longint unsigned fill;
        longint unsigned draw;
        fill = shadow_fifo.size();
        draw = rnd;
        if (fill < cfg_thr_low)
            return 1'b0;
        if (!cls && fill < cfg_thr_high)
            return 1'b0;
        if (cls)
            return draw * (cfg_max_len - cfg_thr_low) < (fill - cfg_thr_low) * PROB_SCALE;
        return draw * (cfg_max_len - cfg_thr_high)
               < (fill - cfg_thr_high) * cfg_drop_pct * PERCENT_SCALE;
    endfunction

    // Applies one item to the shadow queue and returns the result it owes.
    function automatic queue_result_t predict_queue_op(pkt_item_t it);
        queue_result_t res;
        desc_t         head;
        longint unsigned fill;
        res  = '0;
        fill = shadow_fifo.size();
        case (it.op)
            OP_ENQUEUE:
            begin
                if (fill < cfg_max_len && fill < SHADOW_DEPTH
                        && !early_drop(it.drop_class, it.rand_value))
                begin
                    head.tag       = it.pkt_tag;
                    head.is_ip     = it.is_ip;
                    head.ip_length = it.ip_length;
                    shadow_fifo.push_back(head);
                    res.accepted = 1'b1;
                end
            end
            OP_DEQUEUE:
            begin
                if (fill == 0)
                    shadow_credit = 0;
                else
                begin
                    head = shadow_fifo[0];
                    // An IP head waits until its length fits in the credit.
                    if (!head.is_ip || head.ip_length <= shadow_credit)
                    begin
                        if (head.is_ip)
                            shadow_credit = shadow_credit - head.ip_length;
                        shadow_fifo.delete(0);
                        res.out_valid     = 1'b1;
                        res.out_tag       = head.tag;
                        res.out_is_ip     = head.is_ip;
                        res.out_ip_length = head.ip_length;
                    end
                end
            end
            OP_TICK:
            begin
                if (shadow_credit < cfg_unit * CREDIT_UNITS_MAX)
                    shadow_credit = (shadow_credit + cfg_unit) & CREDIT_MASK;
            end
            default:
            begin
            end
        endcase
        res.queue_length = LEN_W'(shadow_fifo.size());
        res.credit       = CREDIT_W'(shadow_credit);
        return res;
    endfunction

    function automatic queue_result_t result_of(logic acc, logic vld, logic [TAG_W-1:0] tag,
            logic ip, logic [IPLEN_W-1:0] len, logic [LEN_W-1:0] fill,
            logic [CREDIT_W-1:0] cr);
        queue_result_t res;
        res.accepted      = acc;
        res.out_valid     = vld;
        res.out_tag       = tag;
        res.out_is_ip     = ip;
        res.out_ip_length = len;
        res.queue_length  = fill;
        res.credit        = cr;
        return res;
    endfunction

    function automatic stim_row_t item_row(logic [1:0] op_code, logic cls, logic ip,
            logic [IPLEN_W-1:0] len, logic [TAG_W-1:0] tag, logic [RAND_W-1:0] rnd,
            logic typed = 1'b0, queue_result_t res = '0);
        stim_row_t row;
        row                 = '0;
        row.kind            = ROW_ITEM;
        row.item.op         = op_code;
        row.item.drop_class = cls;
        row.item.is_ip      = ip;
        row.item.ip_length  = len;
        row.item.pkt_tag    = tag;
        row.item.rand_value = rnd;
        row.typed           = typed;
        row.typed_res       = res;
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
            logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic pkt_item_t random_item(traffic_phase_t ph);
        pkt_item_t   it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < ph.enq_pct)
            it.op = OP_ENQUEUE;
        else if (pick < ph.enq_pct + ph.deq_pct)
            it.op = OP_DEQUEUE;
        else if (pick < ph.enq_pct + ph.deq_pct + ph.tick_pct)
            it.op = OP_TICK;
        else
            it.op = OP_RESERVED;
        it.drop_class = 1'($urandom_range(0, 1));
        it.is_ip      = 1'($urandom_range(0, 1));
        // Mostly lengths that the credit can cover, now and then any length.
        if ($urandom_range(0, 4) == 0)
            it.ip_length = IPLEN_W'($urandom());
        else
            it.ip_length = IPLEN_W'($urandom_range(0, 3000));
        it.pkt_tag = TAG_W'($urandom());
        // Draws above the nominal range show up now and then.
        if ($urandom_range(0, 6) == 0)
            it.rand_value = RAND_W'($urandom_range(0, 16383));
        else
            it.rand_value = RAND_W'($urandom_range(0, 9999));
        return it;
    endfunction

    // Writes one register and mirrors it into the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_LENGTH:       cfg_max_len  = value[LEN_W-1:0];
            CFG_THRESHOLD_LOW:    cfg_thr_low  = value[LEN_W-1:0];
            CFG_THRESHOLD_HIGH:   cfg_thr_high = value[LEN_W-1:0];
            CFG_MAX_DROP_PERCENT: cfg_drop_pct = value[PCT_W-1:0];
            CFG_CREDIT_UNIT:      cfg_unit     = value[UNIT_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Offers one item, waits for it to be taken and records what it owes.
    task automatic drive_item(input pkt_item_t it, input logic typed,
            input queue_result_t typed_res);
        queue_result_t predicted;
        in_valid   <= 1'b1;
        op         <= it.op;
        drop_class <= it.drop_class;
        is_ip      <= it.is_ip;
        ip_length  <= it.ip_length;
        pkt_tag    <= it.pkt_tag;
        rand_value <= it.rand_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_queue_op(it);
        owed_results.push_back(typed ? typed_res : predicted);
    endtask

    // The sender works in bursts; between bursts it drops valid for a while.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(0, 15);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Lets every outstanding result come back before registers change.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: short ready runs broken by stalls, and one long hold-off.
    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                if ($urandom_range(0, 2) != 0)
                begin
                    res_ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
            end
        end
    end

    // Each accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
                check_field("out_tag", 32'(want.out_tag), 32'(out_tag));
                check_field("out_is_ip", 32'(want.out_is_ip), 32'(out_is_ip));
                check_field("out_ip_length", 32'(want.out_ip_length), 32'(out_ip_length));
                check_field("queue_length", 32'(want.queue_length), 32'(queue_length));
                check_field("credit", 32'(want.credit), 32'(credit));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, verdict.
    initial
    begin
        stim_row_t      directed_rows[$];
        traffic_phase_t phases[PHASE_COUNT];

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        op         <= OP_ENQUEUE;
        drop_class <= 1'b0;
        is_ip      <= 1'b0;
        ip_length  <= '0;
        pkt_tag    <= '0;
        rand_value <= '0;

        shadow_credit = 0;
        cfg_max_len   = MAX_LENGTH_RST;
        cfg_thr_low   = THRESHOLD_LOW_RST;
        cfg_thr_high  = THRESHOLD_HIGH_RST;
        cfg_drop_pct  = 10;
        cfg_unit      = CREDIT_UNIT_RST;
        error_count   = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: empty dequeue, unused op, tick, non-IP and IP heads.
        directed_rows.push_back(item_row(OP_DEQUEUE, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd0)));
        directed_rows.push_back(item_row(OP_RESERVED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 14'h3FFF,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd0)));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd1500)));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 14'h3FFF,
            1'b1, result_of(1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 9'd1, 20'd1500)));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b0, 1'b1, 16'd1501, 16'h0000, 14'd0,
            1'b1, result_of(1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 9'd2, 20'd1500)));
        // A non-IP head leaves without touching the credit.
        directed_rows.push_back(item_row(OP_DEQUEUE, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 9'd1, 20'd1500)));
        // The IP head is one byte longer than the credit, so it stays.
        directed_rows.push_back(item_row(OP_DEQUEUE, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd1, 20'd1500)));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd1, 20'd3000)));
        directed_rows.push_back(item_row(OP_DEQUEUE, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b1, 16'h0000, 1'b1, 16'd1501, 9'd0, 20'd1499)));
        // Dequeue on an empty queue clears the credit.
        directed_rows.push_back(item_row(OP_DEQUEUE, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd0)));
        // A zero credit unit makes ticks do nothing.
        directed_rows.push_back(reg_row(CFG_CREDIT_UNIT, 16'd0));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd0)));
        // A zero capacity drops every packet.
        directed_rows.push_back(reg_row(CFG_MAX_LENGTH, 16'd0));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b1, 1'b1, 16'd100, 16'h1234, 14'd9999,
            1'b1, result_of(1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 9'd0, 20'd0)));
        // Tiny queue with low thresholds: both drop rules and the full check.
        directed_rows.push_back(reg_row(CFG_MAX_LENGTH, 16'd4));
        directed_rows.push_back(reg_row(CFG_THRESHOLD_LOW, 16'd1));
        directed_rows.push_back(reg_row(CFG_THRESHOLD_HIGH, 16'd2));
        directed_rows.push_back(reg_row(CFG_MAX_DROP_PERCENT, 16'd100));
        directed_rows.push_back(reg_row(CFG_CREDIT_UNIT, 16'hFFFF));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b1, 1'b1, 16'd0, 16'h5555, 14'd0));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b0, 1'b1, 16'hAAAA, 16'hAAAA, 14'd0));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b0, 1'b0, 16'd7, 16'd3, 14'd0));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b0, 1'b1, 16'd9, 16'd4, 14'd1));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b1, 1'b1, 16'd11, 16'd5, 14'h3FFF));
        directed_rows.push_back(item_row(OP_ENQUEUE, 1'b1, 1'b0, 16'd13, 16'd6, 14'd0));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 14'd0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                drive_item(directed_rows[i].item, directed_rows[i].typed,
                    directed_rows[i].typed_res);
                pace_sender();
            end
        end

        // The first phase fills the queue to the brim with no early drop.
        phases[0] = '{256, 256, 256, 0, 65535, 270, 98, 1, 1};
        phases[1] = '{256, 0, 0, 100, 1500, 25, 30, 50, 15};
        phases[2] = '{200, 100, 150, 50, 65535, 25, 10, 60, 28};
        phases[3] = '{16, 4, 8, 100, $urandom_range(0, 65535), 25, 50, 30, 15};
        phases[4] = '{1, 0, 256, $urandom_range(0, 100), 0, 10, 50, 40, 5};
        phases[5] = '{$urandom_range(1, 256), $urandom_range(0, 256), $urandom_range(0, 256),
                      $urandom_range(0, 100), $urandom_range(0, 65535), 25, 45, 40, 12};

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_reg(CFG_MAX_LENGTH, CFG_DATA_W'(phases[p].max_len));
            write_reg(CFG_THRESHOLD_LOW, CFG_DATA_W'(phases[p].thr_low));
            write_reg(CFG_THRESHOLD_HIGH, CFG_DATA_W'(phases[p].thr_high));
            write_reg(CFG_MAX_DROP_PERCENT, CFG_DATA_W'(phases[p].drop_pct));
            write_reg(CFG_CREDIT_UNIT, CFG_DATA_W'(phases[p].unit));
            // Hold results back while the queue fills so the input stalls.
            if (p == 0)
                hold_off_req = 1'b1;
            for (int n = 0; n < int'(phases[p].items); n++)
            begin
                drive_item(random_item(phases[p]), 1'b0, '0);
                pace_sender();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
